FILE: rtl/window_alpha_overlay_defines.svh
// Assertion macros shared by the window alpha overlay RTL.
`ifndef WINDOW_ALPHA_OVERLAY_DEFINES_SVH
`define WINDOW_ALPHA_OVERLAY_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define WAO_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define WAO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/wao_pkg.sv
// Shared types, register codes and constants of the window alpha overlay.
package wao_pkg;

  localparam int DEF_MAX_WIDTH = 4096;
  localparam int DEF_MAX_BPP   = 4;

  localparam int FW_W    = 13;  // frame_width, win_width, win_height
  localparam int POS_W   = 12;  // win_x, win_y
  localparam int BPP_W   = 3;   // bytes_per_pixel register
  localparam int RATIO_W = 9;
  localparam int ROW_W   = 12;
  localparam int EBPP_W  = 4;   // effective bytes per pixel, holds up to fifteen
  localparam int CFG_W   = 13;
  localparam int IDX_W   = 3;
  localparam int BYTE_W  = 8;

  localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(256);

  typedef enum logic [IDX_W-1:0] {
    REG_FRAME_WIDTH = 3'd0,
    REG_BPP         = 3'd1,
    REG_GREY        = 3'd2,
    REG_WIN_WIDTH   = 3'd3,
    REG_WIN_HEIGHT  = 3'd4,
    REG_WIN_X       = 3'd5,
    REG_WIN_Y       = 3'd6,
    REG_RATIO       = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [FW_W-1:0]    frame_width;
    logic [BPP_W-1:0]   bytes_per_pixel;
    logic               overlay_grey;
    logic [FW_W-1:0]    win_width;
    logic [FW_W-1:0]    win_height;
    logic [POS_W-1:0]   win_x;
    logic [POS_W-1:0]   win_y;
    logic [RATIO_W-1:0] blend_ratio;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    frame_width:     FW_W'(640),
    bytes_per_pixel: BPP_W'(3),
    overlay_grey:    1'b0,
    win_width:       FW_W'(64),
    win_height:      FW_W'(64),
    win_x:           '0,
    win_y:           '0,
    blend_ratio:     RATIO_W'(128)
  };

  // Position decode for the byte being processed.
  typedef struct packed {
    logic hit;
    logic last_byte;
    logic invalid;
  } win_t;

  typedef struct packed {
    logic              params_invalid;
    logic              overlay_advance;
    logic              in_window;
    logic [BYTE_W-1:0] out_byte;
  } res_t;

endpackage

FILE: rtl/wao_pos.sv
// Raster position counters and window decode for the window alpha overlay.
module wao_pos import wao_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_BPP   = DEF_MAX_BPP
) (
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  logic sof,
  input  cfg_t cfg,
  output win_t win
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int PW  = (CW + 1 > FW_W + 1) ? CW + 1 : FW_W + 1;
  localparam int BIW = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;

  logic [CW-1:0]     col_count;
  logic [ROW_W-1:0]  row_count;
  logic [BIW-1:0]    byte_index;
  logic [CW-1:0]     col_next;
  logic [ROW_W-1:0]  row_next;
  logic [BIW-1:0]    byte_index_next;

  logic [EBPP_W-1:0] bpp;
  logic [CW-1:0]     col_cur;
  logic [ROW_W-1:0]  row_cur;
  logic [EBPP_W-1:0] bi_raw;
  logic [EBPP_W-1:0] bi;
  logic [EBPP_W-1:0] bi_inc;
  logic [PW-1:0]     col_inc;
  logic [PW-1:0]     win_x_end;
  logic [FW_W:0]     win_y_end;
  logic              in_rect;

  always_comb begin
    bpp = EBPP_W'(cfg.bytes_per_pixel);
    if (bpp == '0) begin
      bpp = EBPP_W'(1);
    end
    if (bpp > EBPP_W'(MAX_BPP)) begin
      bpp = EBPP_W'(MAX_BPP);
    end
  end

  // A start of frame clears the position before this byte uses it.
  assign col_cur = sof ? '0 : col_count;
  assign row_cur = sof ? '0 : row_count;
  assign bi_raw  = sof ? '0 : EBPP_W'(byte_index);
  // A narrower pixel written since the last byte restarts the pixel.
  assign bi      = (bi_raw >= bpp) ? '0 : bi_raw;
  assign bi_inc  = bi + EBPP_W'(1);

  assign win_x_end = PW'(cfg.win_x) + PW'(cfg.win_width);
  assign win_y_end = (FW_W + 1)'(cfg.win_y) + (FW_W + 1)'(cfg.win_height);

  assign win.invalid   = (win_x_end > PW'(cfg.frame_width)) || (cfg.blend_ratio > RATIO_ONE);
  assign win.last_byte = (bi_inc >= bpp);

  assign in_rect = (PW'(col_cur) >= PW'(cfg.win_x)) && (PW'(col_cur) < win_x_end) &&
                   ((FW_W + 1)'(row_cur) >= (FW_W + 1)'(cfg.win_y)) &&
                   ((FW_W + 1)'(row_cur) < win_y_end);
  assign win.hit = in_rect && !win.invalid;

  assign col_inc = PW'(col_cur) + PW'(1);

  always_comb begin
    col_next        = col_cur;
    row_next        = row_cur;
    byte_index_next = BIW'(bi_inc);
    if (win.last_byte) begin
      byte_index_next = '0;
      if (col_inc >= PW'(cfg.frame_width) || col_inc >= PW'(MAX_WIDTH)) begin
        col_next = '0;
        row_next = row_cur + ROW_W'(1);
      end else begin
        col_next = CW'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count  <= '0;
      row_count  <= '0;
      byte_index <= '0;
    end else if (step) begin
      col_count  <= col_next;
      row_count  <= row_next;
      byte_index <= byte_index_next;
    end
  end

endmodule

FILE: rtl/wao_blend.sv
// Blend arithmetic: (r*bg + (256-r)*ov) >> 8 with a single multiplier.
module wao_blend import wao_pkg::*; (
  input  logic [BYTE_W-1:0]  bg,
  input  logic [BYTE_W-1:0]  ov,
  input  logic [RATIO_W-1:0] ratio,
  output logic [BYTE_W-1:0]  blended
);

  // r*bg + (256-r)*ov equals ov*256 + r*(bg-ov), which stays non-negative for r up to 256.
  logic signed [BYTE_W:0]      diff;
  logic signed [RATIO_W:0]     ratio_s;
  logic signed [RATIO_W+BYTE_W+1:0] prod;
  logic signed [RATIO_W+BYTE_W+2:0] sum;

  assign diff    = $signed({1'b0, bg}) - $signed({1'b0, ov});
  assign ratio_s = $signed({1'b0, ratio});
  assign prod    = ratio_s * diff;
  assign sum     = $signed({4'b0000, ov, 8'h00}) + (RATIO_W + BYTE_W + 3)'(prod);
  assign blended = sum[15:8];

endmodule

FILE: rtl/window_alpha_overlay.sv
// Top level of the window alpha overlay: config registers, two-stage stream pipeline.
//
//   channel  direction  handshake          payload
//   s_*      in         s_tvalid/s_tready  tdata: bg_byte, overlay_byte; tuser: start_of_frame
//   m_*      out        m_tvalid/m_tready  tdata: out_byte; tuser: in_window, advance, invalid
//   cfg_*    in         cfg_we             cfg_index, cfg_data
//
// One byte is accepted per cycle while m_tready does not stall the pipeline; its result
// passes through the input register and then the result register before it is offered.
// The input register feeds the position decode and one 10x9 multiply into the result register.
// Synchronous reset clears the counters, both valid flags and the registers to defaults.
// A stall on m_tready holds the result; the input stage keeps taking bytes until both fill.
`include "window_alpha_overlay_defines.svh"

module window_alpha_overlay import wao_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_BPP   = DEF_MAX_BPP
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [15:0]       s_tdata,   // [7:0] bg_byte, [15:8] overlay_byte
  input  logic              s_tuser,   // [0] start_of_frame
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,   // [7:0] out_byte
  output logic [2:0]        m_tuser,   // [0] in_window, [1] overlay_advance, [2] params_invalid
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  cfg_t              cfg;
  logic              a_valid;
  logic              a_sof;
  logic [BYTE_W-1:0] a_bg;
  logic [BYTE_W-1:0] a_ov;
  logic              a_ready;
  logic              b_valid;
  logic              b_ready;
  res_t              b_res;
  res_t              res_next;
  win_t              win;
  logic [BYTE_W-1:0] blended;
  logic              a_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_FRAME_WIDTH: cfg.frame_width     <= cfg_data[FW_W-1:0];
        REG_BPP:         cfg.bytes_per_pixel <= cfg_data[BPP_W-1:0];
        REG_GREY:        cfg.overlay_grey    <= cfg_data[0];
        REG_WIN_WIDTH:   cfg.win_width       <= cfg_data[FW_W-1:0];
        REG_WIN_HEIGHT:  cfg.win_height      <= cfg_data[FW_W-1:0];
        REG_WIN_X:       cfg.win_x           <= cfg_data[POS_W-1:0];
        REG_WIN_Y:       cfg.win_y           <= cfg_data[POS_W-1:0];
        REG_RATIO:       cfg.blend_ratio     <= cfg_data[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  assign b_ready  = !b_valid || m_tready;
  assign a_ready  = !a_valid || b_ready;
  assign s_tready = a_ready;
  assign a_move   = a_valid && b_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && s_tvalid) begin
      a_sof <= s_tuser;
      a_bg  <= s_tdata[7:0];
      a_ov  <= s_tdata[15:8];
    end
  end

  wao_pos #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_BPP  (MAX_BPP)
  ) u_pos (
    .clk (clk),
    .rst (rst),
    .step(a_move),
    .sof (a_sof),
    .cfg (cfg),
    .win (win)
  );

  wao_blend u_blend (
    .bg     (a_bg),
    .ov     (a_ov),
    .ratio  (cfg.blend_ratio),
    .blended(blended)
  );

  always_comb begin
    res_next.out_byte        = win.hit ? blended : a_bg;
    res_next.in_window       = win.hit;
    res_next.overlay_advance = win.hit && (!cfg.overlay_grey || win.last_byte);
    res_next.params_invalid  = win.invalid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      b_res <= res_next;
    end
  end

  assign m_tvalid = b_valid;
  assign m_tdata  = b_res.out_byte;
  assign m_tuser  = {b_res.params_invalid, b_res.overlay_advance, b_res.in_window};

  `WAO_ASSERT_IMPL(a_invalid_no_window, b_valid && b_res.params_invalid, !b_res.in_window, "window flagged while parameters invalid")
  `WAO_ASSERT_IMPL(a_advance_in_window, b_valid && b_res.overlay_advance, b_res.in_window, "overlay advance outside the window")
  `WAO_ASSERT_IMPL(a_empty_out_ready, !b_valid, s_tready, "input stalled with empty result register")
  `WAO_ASSERT_NEXT(a_stage_hold, a_valid && !b_ready, a_valid, "input stage dropped a held transaction")

endmodule

FILE: verif/window_alpha_overlay_checker.sv
// Checker for the window alpha overlay: follows settings and raster position, predicts each result.
`timescale 1ns / 100ps

module window_alpha_overlay_checker import wao_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [15:0]      s_tdata,   // [7:0] bg_byte, [15:8] overlay_byte
  input  logic             s_tuser,   // [0] start_of_frame
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [7:0]       m_tdata,   // [7:0] out_byte
  input  logic [2:0]       m_tuser,   // [0] in_window, [1] overlay_advance, [2] params_invalid
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output int               mismatches,
  output int               outstanding,
  output int               compared,
  output int               blended,
  output int               bypassed
);

  cfg_t             regs;
  logic [ROW_W-1:0] col_pos;
  logic [ROW_W-1:0] row_pos;
  int unsigned      byte_pos;
  res_t             expected_blends[$];

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      // Keep the log readable when the design is badly off.
      if (mismatches <= 50) $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // Works out the result for one byte at the current position, then moves the position on.
  function automatic res_t blend_next(input logic sof, input logic [7:0] bg, input logic [7:0] ov);
    int unsigned ebpp, ratio, x0, x1, y0, y1;
    logic        bad, hit, last;
    res_t        r;
    ebpp = (regs.bytes_per_pixel == '0) ? 1 : int'(regs.bytes_per_pixel);
    if (ebpp > DEF_MAX_BPP) ebpp = DEF_MAX_BPP;
    ratio = regs.blend_ratio;
    x0 = regs.win_x;
    x1 = x0 + regs.win_width;
    y0 = regs.win_y;
    y1 = y0 + regs.win_height;
    if (sof) begin
      col_pos  = '0;
      row_pos  = '0;
      byte_pos = 0;
    end
    // A pixel size shrunk since the last byte restarts the pixel.
    if (byte_pos >= ebpp) byte_pos = 0;
    bad  = (x1 > regs.frame_width) || (ratio > 256);
    hit  = !bad && col_pos >= x0 && col_pos < x1 && row_pos >= y0 && row_pos < y1;
    last = (byte_pos + 1 >= ebpp);
    r.out_byte        = bg;
    r.in_window       = hit;
    r.overlay_advance = 1'b0;
    r.params_invalid  = bad;
    if (hit) begin
      r.out_byte        = BYTE_W'((ratio * bg + (256 - ratio) * ov) >> 8);
      r.overlay_advance = !regs.overlay_grey || last;
    end
    if (last) begin
      byte_pos = 0;
      if (int'(col_pos) + 1 >= regs.frame_width || int'(col_pos) + 1 >= DEF_MAX_WIDTH) begin
        col_pos = '0;
        row_pos = row_pos + 1'b1;
      end else begin
        col_pos = col_pos + 1'b1;
      end
    end else begin
      byte_pos = byte_pos + 1;
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    res_t want;
    if (rst) begin
      regs = '{frame_width: FW_W'(640), bytes_per_pixel: BPP_W'(3), overlay_grey: 1'b0,
               win_width: FW_W'(64), win_height: FW_W'(64), win_x: '0, win_y: '0,
               blend_ratio: RATIO_W'(128)};
      col_pos  = '0;
      row_pos  = '0;
      byte_pos = 0;
      expected_blends.delete();
    end else begin
      // Results leave only after passing the input and result registers, so retire before predicting.
      if (m_tvalid && m_tready) begin
        compared++;
        if (expected_blends.size() == 0) begin
          mismatches++;
          $error("result with nothing expected: out_byte %0d, flags %b", m_tdata, m_tuser);
        end else begin
          want = expected_blends.pop_front();
          check_field("out_byte", want.out_byte, m_tdata);
          check_field("in_window", want.in_window, m_tuser[0]);
          check_field("overlay_advance", want.overlay_advance, m_tuser[1]);
          check_field("params_invalid", want.params_invalid, m_tuser[2]);
        end
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          REG_FRAME_WIDTH: regs.frame_width     = cfg_data[FW_W-1:0];
          REG_BPP:         regs.bytes_per_pixel = cfg_data[BPP_W-1:0];
          REG_GREY:        regs.overlay_grey    = cfg_data[0];
          REG_WIN_WIDTH:   regs.win_width       = cfg_data[FW_W-1:0];
          REG_WIN_HEIGHT:  regs.win_height      = cfg_data[FW_W-1:0];
          REG_WIN_X:       regs.win_x           = cfg_data[POS_W-1:0];
          REG_WIN_Y:       regs.win_y           = cfg_data[POS_W-1:0];
          REG_RATIO:       regs.blend_ratio     = cfg_data[RATIO_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        want = blend_next(s_tuser, s_tdata[7:0], s_tdata[15:8]);
        if (want.in_window) blended++;
        if (want.params_invalid) bypassed++;
        expected_blends.push_back(want);
      end
    end
    outstanding <= expected_blends.size();
  end

endmodule

FILE: verif/window_alpha_overlay_test.sv
// Testbench top for the window alpha overlay: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module window_alpha_overlay_test import wao_pkg::*;;

  localparam int RUN_LIMIT_NS = 8_000_000;
  localparam int RANDOM_BYTES = 750;

  typedef enum logic [1:0] {SINK_FREE, SINK_COIN, SINK_TRICKLE, SINK_BEAT} sink_mode_t;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             s_tvalid  = 1'b0;
  logic             s_tready;
  logic [15:0]      s_tdata   = '0;   // [7:0] bg_byte, [15:8] overlay_byte
  logic             s_tuser   = 1'b0; // [0] start_of_frame
  logic             m_tvalid;
  logic             m_tready  = 1'b0;
  logic [7:0]       m_tdata;          // [7:0] out_byte
  logic [2:0]       m_tuser;          // [0] in_window, [1] overlay_advance, [2] params_invalid
  logic             cfg_we    = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data  = '0;

  int          mismatches, outstanding, compared, blended, bypassed;
  cfg_t        window_cfg;
  int          burst_left;
  int          settings_used;
  int          random_sent;
  sink_mode_t  sink_mode = SINK_FREE;
  int          sink_left = 0;
  logic [31:0] sink_tick = '0;

  window_alpha_overlay dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  window_alpha_overlay_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .compared    (compared),
    .blended     (blended),
    .bypassed    (bypassed)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("tb: failure");
    $finish;
  end

  // The receiver switches between free flow, coin flips, a trickle and a fixed beat.
  always @(posedge clk) begin
    sink_tick <= sink_tick + 1;
    if (sink_left == 0) begin
      sink_mode <= sink_mode_t'($urandom_range(0, 3));
      sink_left <= $urandom_range(8, 150);
    end else begin
      sink_left <= sink_left - 1;
    end
    case (sink_mode)
      SINK_FREE:    m_tready <= 1'b1;
      SINK_COIN:    m_tready <= 1'($urandom_range(0, 1));
      SINK_TRICKLE: m_tready <= ($urandom_range(0, 4) == 0);
      default:      m_tready <= (sink_tick[2:0] >= 3'd6);
    endcase
  end

  task automatic push_byte(input logic sof, input logic [7:0] bg, input logic [7:0] ov);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(80, 300) : $urandom_range(1, 24);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {ov, bg};
    s_tuser  <= sof;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Holds the sender until every expected result is back, then adds a slack wait.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Narrow registers get random junk above their width, which the block must drop.
  task automatic program_window(input cfg_t c);
    logic [CFG_W-1:0] junk;
    settle();
    junk = CFG_W'($urandom);
    write_reg(REG_FRAME_WIDTH, c.frame_width);
    write_reg(REG_BPP, {junk[CFG_W-1:BPP_W], c.bytes_per_pixel});
    write_reg(REG_GREY, {junk[CFG_W-1:1], c.overlay_grey});
    write_reg(REG_WIN_WIDTH, c.win_width);
    write_reg(REG_WIN_HEIGHT, c.win_height);
    write_reg(REG_WIN_X, {junk[CFG_W-1:POS_W], c.win_x});
    write_reg(REG_WIN_Y, {junk[CFG_W-1:POS_W], c.win_y});
    write_reg(REG_RATIO, {junk[CFG_W-1:RATIO_W], c.blend_ratio});
    cfg_we <= 1'b0;
    @(posedge clk);
    window_cfg = c;
    settings_used++;
  endtask

  function automatic cfg_t window_of(input int fw, input int bpp, input int grey, input int ww,
                                     input int wh, input int wx, input int wy, input int ratio);
    cfg_t c;
    c.frame_width     = FW_W'(fw);
    c.bytes_per_pixel = BPP_W'(bpp);
    c.overlay_grey    = 1'(grey);
    c.win_width       = FW_W'(ww);
    c.win_height      = FW_W'(wh);
    c.win_x           = POS_W'(wx);
    c.win_y           = POS_W'(wy);
    c.blend_ratio     = RATIO_W'(ratio);
    return c;
  endfunction

  function automatic cfg_t random_window();
    cfg_t        c;
    int unsigned fw, wx;
    c.bytes_per_pixel = BPP_W'($urandom_range(0, 7));
    c.overlay_grey    = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 9) == 0) begin
      // Wide frames, to reach the largest window sizes and offsets.
      fw           = $urandom_range(0, 1) ? DEF_MAX_WIDTH : $urandom_range(DEF_MAX_WIDTH, 8191);
      wx           = $urandom_range(0, 1) ? 0 : $urandom_range(0, DEF_MAX_WIDTH - 1);
      c.win_width  = FW_W'($urandom_range(0, 1) ? DEF_MAX_WIDTH - wx
                                                : $urandom_range(0, DEF_MAX_WIDTH));
      c.win_y      = POS_W'($urandom_range(0, 1) ? 0 : $urandom_range(0, 4095));
      c.win_height = FW_W'($urandom_range(0, 1) ? DEF_MAX_WIDTH : $urandom_range(0, 8));
    end else begin
      fw           = $urandom_range(0, 12);
      wx           = $urandom_range(0, fw);
      // One past the fitting width makes the window overhang the frame.
      c.win_width  = FW_W'($urandom_range(0, fw - wx + 1));
      c.win_y      = POS_W'($urandom_range(0, 4));
      c.win_height = FW_W'($urandom_range(0, 5));
    end
    c.frame_width = FW_W'(fw);
    c.win_x       = POS_W'(wx);
    case ($urandom_range(0, 7))
      0:       c.blend_ratio = '0;
      1:       c.blend_ratio = RATIO_W'(256);
      2:       c.blend_ratio = RATIO_W'($urandom_range(0, 1) ? 511 : $urandom_range(257, 511));
      default: c.blend_ratio = RATIO_W'($urandom_range(1, 255));
    endcase
    return c;
  endfunction

  // Mostly whole frames opened by a frame start, with some cut short and some stray starts.
  task automatic stream_frames(input int count, input bit carry);
    int unsigned ew, eb, rows, left;
    logic        sof;
    ew = (window_cfg.frame_width == '0) ? 1 : int'(window_cfg.frame_width);
    if (ew > DEF_MAX_WIDTH) ew = DEF_MAX_WIDTH;
    eb = (window_cfg.bytes_per_pixel == '0) ? 1 : int'(window_cfg.bytes_per_pixel);
    if (eb > DEF_MAX_BPP) eb = DEF_MAX_BPP;
    rows = window_cfg.win_y + window_cfg.win_height + 1;
    if (rows > 6) rows = 6;
    // A carried phase picks up the frame that the previous settings left under way.
    left = carry ? $urandom_range(1, ew * eb) : 0;
    for (int i = 0; i < count; i++) begin
      sof = 1'b0;
      if (left == 0) begin
        left = ew * eb * $urandom_range(1, rows);
        if ($urandom_range(0, 7) == 0) left = $urandom_range(1, left);
        sof = 1'b1;
      end else if ($urandom_range(0, 49) == 0) begin
        sof = 1'b1;
      end
      push_byte(sof, 8'($urandom), 8'($urandom));
      left--;
      random_sent++;
    end
  endtask

  initial begin
    burst_left    = 0;
    settings_used = 1;
    random_sent   = 0;
    window_cfg    = window_of(640, 3, 0, 64, 64, 0, 0, 128);
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Settings from reset: the first pixels of a frame sit in the default window.
    push_byte(1'b1, 8'd0, 8'd255);
    push_byte(1'b0, 8'd255, 8'd0);
    push_byte(1'b0, 8'd255, 8'd255);
    push_byte(1'b0, 8'd0, 8'd0);
    push_byte(1'b0, 8'h55, 8'hAA);
    push_byte(1'b0, 8'hAA, 8'h55);

    // Zero pixel size counts as one; full background weight; a one-pixel window.
    program_window(window_of(2, 0, 1, 1, 1, 1, 0, 256));
    push_byte(1'b1, 8'd200, 8'd17);
    push_byte(1'b0, 8'd201, 8'd18);
    push_byte(1'b0, 8'd3, 8'd4);
    push_byte(1'b0, 8'd5, 8'd6);

    // Oversized pixel size saturates at four; grey overlay advances on the last byte only.
    program_window(window_of(3, 7, 1, 3, 2, 0, 0, 0));
    push_byte(1'b1, 8'd255, 8'd1);
    push_byte(1'b0, 8'd255, 8'd2);
    push_byte(1'b0, 8'd255, 8'd3);
    push_byte(1'b0, 8'd255, 8'd4);
    push_byte(1'b0, 8'd0, 8'd255);

    // Window overhangs the frame; the first byte also meets a pixel position past the new size.
    program_window(window_of(4, 1, 0, 3, 2, 2, 0, 100));
    push_byte(1'b0, 8'd9, 8'd90);
    push_byte(1'b1, 8'd10, 8'd91);
    push_byte(1'b0, 8'd11, 8'd92);

    // Background weight above one is rejected even on a zero-width frame.
    program_window(window_of(0, 2, 0, 0, 0, 0, 0, 257));
    push_byte(1'b1, 8'd77, 8'd88);
    push_byte(1'b0, 8'd78, 8'd89);

    // Empty window on a zero-width frame is valid but never hit.
    program_window(window_of(0, 2, 1, 0, 0, 0, 0, 255));
    push_byte(1'b1, 8'd1, 8'd2);
    push_byte(1'b0, 8'd3, 8'd4);

    while (random_sent < RANDOM_BYTES) begin
      program_window(random_window());
      stream_frames($urandom_range(30, 120), $urandom_range(0, 3) == 0);
    end

    settle();
    $display("summary: %0d results compared under %0d window settings", compared, settings_used);
    $display("summary: %0d bytes blended in the window, %0d passed through a rejected window",
             blended, bypassed);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
